>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the pulse tone channel.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, off while the given active-low reset is low.
`define PTS_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property on the block clock aclk with reset aresetn.
`define PTS_ASSERT(label, prop, msg) \
    `PTS_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

>>> rtl/pts_pkg.sv
// Shared types, codes and helper functions of the pulse tone sweep channel.
// No dependencies; used by pts_core and pulse_tone_sweep_channel.
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

    localparam int PERIOD_W = 11;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 11'h7FF;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN = 11'h008;

    // Item operations
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TIMER = 2'd1;
    localparam logic [1:0] OP_SWEEP = 2'd2;

    // Register selects for a write
    localparam logic [2:0] REG_DUTY     = 3'd0;
    localparam logic [2:0] REG_SWEEP    = 3'd1;
    localparam logic [2:0] REG_TIMER_LO = 3'd2;
    localparam logic [2:0] REG_TIMER_HI = 3'd3;
    localparam logic [2:0] REG_ENABLE   = 3'd4;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] reg_select;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic                tone_gate;
        logic                sweep_muted;
        logic [PERIOD_W-1:0] period;
    } status_t;

    // Mute when the period is too short, or an upward step would overflow.
    function automatic logic is_muted(
        input logic [PERIOD_W-1:0] period,
        input logic                down,
        input logic [2:0]          shift
    );
        logic [PERIOD_W:0] target;
        target = {1'b0, period} + {1'b0, (period >> shift)};
        return (period < PERIOD_MIN) || (!down && (target > {1'b0, PERIOD_MAX}));
    endfunction

    // Duty waveform: bit i of the row is the gate at duty step i.
    function automatic logic duty_bit(input logic [1:0] mode, input logic [2:0] step);
        logic [7:0] row;
        unique case (mode)
            2'd0: row = 8'b1000_0000;
            2'd1: row = 8'b1100_0000;
            2'd2: row = 8'b1111_0000;
            2'd3: row = 8'b0011_1111;
        endcase
        return row[step];
    endfunction

endpackage

`default_nettype wire

>>> rtl/pts_core.sv
// Channel state of the pulse tone sweep channel: registers, timer, duty step
// and sweep unit, plus the status of the state after the update. Uses pts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pts_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            item_en,
    input  wire pts_pkg::item_t  item,
    input  wire logic            extra_sub,
    output pts_pkg::status_t     status_next
);

    logic [pts_pkg::PERIOD_W-1:0] period_reg, period_next;
    logic [pts_pkg::PERIOD_W-1:0] count_reg, count_next;
    logic [2:0] step_reg, step_next;
    logic [1:0] mode_reg, mode_next;
    logic       on_reg, on_next;
    logic       sweep_on_reg, sweep_on_next;
    logic [2:0] sweep_per_reg, sweep_per_next;
    logic       down_reg, down_next;
    logic [2:0] shift_reg, shift_next;
    logic       reload_reg, reload_next;
    logic [2:0] divider_reg, divider_next;

    logic                         cur_muted;
    logic                         next_muted;
    logic [pts_pkg::PERIOD_W-1:0] change;

    assign cur_muted = pts_pkg::is_muted(period_reg, down_reg, shift_reg);
    assign change    = period_reg >> shift_reg;

    always_comb begin
        period_next    = period_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        mode_next      = mode_reg;
        on_next        = on_reg;
        sweep_on_next  = sweep_on_reg;
        sweep_per_next = sweep_per_reg;
        down_next      = down_reg;
        shift_next     = shift_reg;
        reload_next    = reload_reg;
        divider_next   = divider_reg;
        if (item_en) begin
            unique case (item.op)
                pts_pkg::OP_WRITE: begin
                    unique case (item.reg_select)
                        pts_pkg::REG_DUTY: begin
                            mode_next = item.write_data[7:6];
                        end
                        pts_pkg::REG_SWEEP: begin
                            sweep_on_next  = item.write_data[7];
                            sweep_per_next = item.write_data[6:4];
                            down_next      = item.write_data[3];
                            shift_next     = item.write_data[2:0];
                            reload_next    = 1'b1;
                        end
                        pts_pkg::REG_TIMER_LO: begin
                            period_next = {period_reg[10:8], item.write_data};
                        end
                        pts_pkg::REG_TIMER_HI: begin
                            period_next = {item.write_data[2:0], period_reg[7:0]};
                            step_next   = 3'd0;
                        end
                        pts_pkg::REG_ENABLE: begin
                            on_next = (item.write_data != 8'd0);
                        end
                        default: begin
                        end
                    endcase
                end
                pts_pkg::OP_TIMER: begin
                    // reload and step the duty sequencer downward on expiry
                    if (count_reg == '0) begin
                        step_next  = step_reg - 3'd1;
                        count_next = period_reg;
                    end else begin
                        count_next = count_reg - 11'd1;
                    end
                end
                pts_pkg::OP_SWEEP: begin
                    if ((divider_reg == 3'd0) && sweep_on_reg && !cur_muted
                            && (shift_reg != 3'd0)) begin
                        if (down_reg) begin
                            period_next = period_reg - change
                                          - {{(pts_pkg::PERIOD_W-1){1'b0}}, extra_sub};
                        end else begin
                            period_next = period_reg + change;
                        end
                    end
                    if ((divider_reg == 3'd0) || reload_reg) begin
                        divider_next = sweep_per_reg;
                        reload_next  = 1'b0;
                    end else begin
                        divider_next = divider_reg - 3'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign next_muted = pts_pkg::is_muted(period_next, down_next, shift_next);

    always_comb begin
        status_next.sweep_muted = next_muted;
        status_next.period      = period_next;
        status_next.tone_gate   = on_next && !next_muted
                                  && pts_pkg::duty_bit(mode_next, step_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= '0;
            count_reg     <= '0;
            step_reg      <= '0;
            mode_reg      <= '0;
            on_reg        <= 1'b0;
            sweep_on_reg  <= 1'b0;
            sweep_per_reg <= '0;
            down_reg      <= 1'b0;
            shift_reg     <= '0;
            reload_reg    <= 1'b0;
            divider_reg   <= '0;
        end else begin
            period_reg    <= period_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            mode_reg      <= mode_next;
            on_reg        <= on_next;
            sweep_on_reg  <= sweep_on_next;
            sweep_per_reg <= sweep_per_next;
            down_reg      <= down_next;
            shift_reg     <= shift_next;
            reload_reg    <= reload_next;
            divider_reg   <= divider_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pulse_tone_sweep_channel.sv
// Pulse tone sweep channel top level: request and result registers around
// the channel state in pts_core. Depends on pts_pkg, pts_core, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Square-wave tone channel with a period sweep. Each request on the s_ channel
// is a register write, a timer tick or a half-frame sweep tick; each request
// yields exactly one result on the m_ channel with the gate, mute flag and
// period of the channel state after that request. The block takes one request
// per clock unless the result register is full and not being taken. The
// accepting edge loads the request register; the request then passes through the
// state update into the result register, after which m_valid is high until the
// result is taken. The request register advances whenever the result register is
// empty or being taken, so throughput stays one request per cycle as long as
// m_ready is high. cfg_extra_negate_subtract sets the amount subtracted on a
// downward sweep (1 for the first channel, 0 for the second); write it only
// while no request is in flight. Envelope and length counter are not present.
module pulse_tone_sweep_channel (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_extra_negate_subtract,
    // requests
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [2:0]  s_reg_select,
    input  wire logic [7:0]  s_write_data,
    // results
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_tone_gate,
    output logic             m_sweep_muted,
    output logic [10:0]      m_period
);

    logic             extra_reg;
    logic             in_valid_reg;
    pts_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    pts_pkg::status_t out_status_reg;
    pts_pkg::status_t status_next;
    logic             advance;

    // The register is always writable; writes are registered.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            extra_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            extra_reg <= cfg_extra_negate_subtract;
        end
    end

    // Move the held request into the state when the result slot is free or being taken.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Payload needs no reset; capture on every accepted request.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.op         <= s_op;
            in_item_reg.reg_select <= s_reg_select;
            in_item_reg.write_data <= s_write_data;
        end
    end

    pts_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_en     (advance),
        .item        (in_item_reg),
        .extra_sub   (extra_reg),
        .status_next (status_next)
    );

    // Result register: load on advance, drop the valid flag once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_status_reg <= status_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_tone_gate   = out_status_reg.tone_gate;
    assign m_sweep_muted = out_status_reg.sweep_muted;
    assign m_period      = out_status_reg.period;

    `PTS_ASSERT(a_held_request_kept, (in_valid_reg && !advance) |=> in_valid_reg, "request lost in request register")
    `PTS_ASSERT(a_advance_gives_result, advance |=> out_valid_reg, "advanced request produced no result")
    `PTS_ASSERT(a_short_period_muted, (m_valid && (m_period < pts_pkg::PERIOD_MIN)) |-> m_sweep_muted, "short period not muted")
    `PTS_ASSERT(a_gate_off_when_muted, (m_valid && m_sweep_muted) |-> !m_tone_gate, "gate high while muted")

endmodule

`default_nettype wire
